// ----- rtl/core/api_rfc_pkg.sv -----
package api_rfc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [BYTE_W-1:0] START_DELIM = 8'h7E;
   localparam logic [BYTE_W-1:0] GOOD_SUM = 8'hFF;
   localparam logic [LEN_W-1:0] MIN_BODY_FOR_ID = 16'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_ID = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_POSITION = 8'd1;

   localparam logic [BYTE_W-1:0] EXPECTED_ID_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] CODE_POSITION_RESET = 8'd1;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } byte_xfer_type;

   typedef struct packed {
      logic [BYTE_W-1:0] expected_id;
      logic [BYTE_W-1:0] code_position;
   } cfg_type;

endpackage

// ----- rtl/core/api_rfc_in_stage.sv -----
module api_rfc_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [api_rfc_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                          advance,
   output api_rfc_pkg::byte_xfer_type    held
);
   import api_rfc_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;
   logic              take;

   assign req_ready = !valid_ff || advance;
   assign take = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign held.valid = valid_ff;
   assign held.data = data_ff;

endmodule

// ----- rtl/core/api_rfc_parser.sv -----
module api_rfc_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  api_rfc_pkg::byte_xfer_type      held,
   input  api_rfc_pkg::cfg_type            cfg,
   output logic                            advance,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [api_rfc_pkg::STATUS_W-1:0] rsp_status,
   output logic [api_rfc_pkg::BYTE_W-1:0]  rsp_frame_type,
   output logic [api_rfc_pkg::BYTE_W-1:0]  rsp_frame_id,
   output logic [api_rfc_pkg::BYTE_W-1:0]  rsp_code,
   output logic [api_rfc_pkg::LEN_W-1:0]   rsp_body_length
);
   import api_rfc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] code_ff, code_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [BYTE_W-1:0]   out_type_ff, out_type_in;
   logic [BYTE_W-1:0]   out_id_ff, out_id_in;
   logic [BYTE_W-1:0]   out_code_ff, out_code_in;
   logic [LEN_W-1:0]    out_length_ff, out_length_in;

   logic              last_byte;
   logic              out_free;
   logic              emit;
   logic [BYTE_W-1:0] sum_next;

   assign last_byte = (phase_ff == PH_BODY) && (index_ff == length_ff);
   assign out_free = !out_valid_ff || rsp_ready;
   assign advance = held.valid && (out_free || !last_byte);
   assign emit = advance && last_byte;
   assign sum_next = sum_ff + held.data;

   always_comb begin
      phase_in = phase_ff;
      len_hi_in = len_hi_ff;
      length_in = length_ff;
      index_in = index_ff;
      sum_in = sum_ff;
      type_in = type_ff;
      id_in = id_ff;
      code_in = code_ff;
      if (advance) begin
         case (phase_ff)
            PH_IDLE: begin
               if (held.data == START_DELIM) begin
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_hi_in = held.data;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {len_hi_ff, held.data};
               index_in = '0;
               sum_in = '0;
               type_in = '0;
               id_in = '0;
               code_in = '0;
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               sum_in = sum_next;
               if (last_byte) begin
                  index_in = '0;
                  phase_in = PH_IDLE;
               end else begin
                  if (index_ff == LEN_W'(0)) begin
                     type_in = held.data;
                  end
                  if (index_ff == LEN_W'(1)) begin
                     id_in = held.data;
                  end
                  if (index_ff == LEN_W'(cfg.code_position)) begin
                     code_in = held.data;
                  end
                  index_in = index_ff + LEN_W'(1);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_type_in = out_type_ff;
      out_id_in = out_id_ff;
      out_code_in = out_code_ff;
      out_length_in = out_length_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (sum_next != GOOD_SUM) begin
            out_status_in = ST_BAD_SUM;
         end else if (length_ff < MIN_BODY_FOR_ID) begin
            out_status_in = ST_SHORT;
         end else if (id_ff != cfg.expected_id) begin
            out_status_in = ST_BAD_ID;
         end else begin
            out_status_in = ST_OK;
         end
         out_type_in = type_ff;
         out_id_in = id_ff;
         out_code_in = code_ff;
         out_length_in = length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         length_ff <= '0;
         index_ff <= '0;
         sum_ff <= '0;
         type_ff <= '0;
         id_ff <= '0;
         code_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         length_ff <= length_in;
         index_ff <= index_in;
         sum_ff <= sum_in;
         type_ff <= type_in;
         id_ff <= id_in;
         code_ff <= code_in;
         out_valid_ff <= out_valid_in;
      end
      len_hi_ff <= len_hi_in;
      out_status_ff <= out_status_in;
      out_type_ff <= out_type_in;
      out_id_ff <= out_id_in;
      out_code_ff <= out_code_in;
      out_length_ff <= out_length_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_frame_type = out_type_ff;
   assign rsp_frame_id = out_id_ff;
   assign rsp_code = out_code_ff;
   assign rsp_body_length = out_length_ff;

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (index_ff <= length_ff))
      else $error("byte index has run past the frame length");

   a_result_from_body: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(phase_ff == PH_BODY))
      else $error("result raised outside the body phase");

   a_result_ends_frame: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_IDLE) && out_valid_ff)
      else $error("frame end did not return to idle with a result");

   a_short_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == ST_OK || out_status_ff == ST_BAD_ID))
         |-> (out_length_ff >= MIN_BODY_FOR_ID))
      else $error("short frame reported with an identifier status");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !emit)
      else $error("result overwritten before its transfer");

endmodule

// ----- rtl/core/api_response_frame_checker_core.sv -----
// A byte transfer that closes a frame is held in the input stage, then its result is registered in the result register.
// Throughput: one received byte per cycle; the result register frees the input side,
// so only the frame-closing byte waits while an earlier result is still untaken.
// Configuration writes apply to every byte that the parser takes after their transfer.
// Synchronous active-high reset returns the parser to waiting for a start delimiter,
// empties both stages and sets expected_id to 0 and code_position to 1.
module api_response_frame_checker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [api_rfc_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [api_rfc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [api_rfc_pkg::BYTE_W-1:0]     rsp_frame_type,
   output logic [api_rfc_pkg::BYTE_W-1:0]     rsp_frame_id,
   output logic [api_rfc_pkg::BYTE_W-1:0]     rsp_code,
   output logic [api_rfc_pkg::LEN_W-1:0]      rsp_body_length,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [api_rfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [api_rfc_pkg::BYTE_W-1:0]     csr_wdata
);
   import api_rfc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   byte_xfer_type held;
   logic          advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_EXPECTED_ID: cfg_in.expected_id = csr_wdata;
            REG_CODE_POSITION: cfg_in.code_position = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_id <= EXPECTED_ID_RESET;
         cfg_ff.code_position <= CODE_POSITION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   api_rfc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .held        (held)
   );

   api_rfc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .held            (held),
      .cfg             (cfg_ff),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_code        (rsp_code),
      .rsp_body_length (rsp_body_length)
   );

endmodule
